// File: rtl/ssi_pkg.sv
// ============================================================================
// ssi_pkg: shared types and constants of the segment intersection core
// Coordinate width, derived arithmetic widths, the input and result item
// structs and the control bundle that travels along the divider chain.
// ============================================================================
package ssi_pkg;

    // Width of one coordinate field. The ports are fixed to it.
    localparam int COORD_BITS = 16;
    // Difference of two coordinates.
    localparam int DIFF_W = COORD_BITS + 1;
    // Product of two differences.
    localparam int PROD_W = 2 * COORD_BITS + 2;
    // Difference of two products (cross product).
    localparam int CROSS_W = 2 * COORD_BITS + 3;
    // Magnitude of the determinant and of the numerators.
    localparam int DIV_W = 2 * COORD_BITS + 1;
    // Magnitude of a direction component.
    localparam int MAG_W = COORD_BITS;
    // Direction magnitude times numerator.
    localparam int NUM_W = MAG_W + DIV_W;
    // Result coordinate width.
    localparam int OUT_W = 32;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] seg_a_start_x;
        logic signed [COORD_BITS-1:0] seg_a_start_y;
        logic signed [COORD_BITS-1:0] seg_a_end_x;
        logic signed [COORD_BITS-1:0] seg_a_end_y;
        logic signed [COORD_BITS-1:0] seg_b_start_x;
        logic signed [COORD_BITS-1:0] seg_b_start_y;
        logic signed [COORD_BITS-1:0] seg_b_end_x;
        logic signed [COORD_BITS-1:0] seg_b_end_y;
    } t_seg_in;

    typedef struct packed {
        logic                    hit;
        logic signed [OUT_W-1:0] cross_x;
        logic signed [OUT_W-1:0] cross_y;
    } t_seg_out;

    // Per-item control that moves along the pipeline and the cell chain.
    typedef struct packed {
        logic valid;
        logic hit;
        logic neg_x;
        logic neg_y;
    } t_ctl;

endpackage

// File: rtl/ssi_front.sv
// ============================================================================
// ssi_front: cross products, hit test and dividend setup
// Six pipeline stages: differences, products, determinant and numerators,
// sign normalization with the range test, split products, and the dividend
// assembly that loads the first divider cell.
// ============================================================================
module ssi_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  ssi_pkg::t_seg_in                       i_item,
    output ssi_pkg::t_ctl                          o_ctl,
    output logic [ssi_pkg::DIV_W-1:0]              o_rem_x,
    output logic [ssi_pkg::DIV_W-1:0]              o_rem_y,
    output logic [ssi_pkg::COORD_BITS+FRAC_BITS-1:0] o_bits_x,
    output logic [ssi_pkg::COORD_BITS+FRAC_BITS-1:0] o_bits_y,
    output logic [ssi_pkg::DIV_W-1:0]              o_div,
    output logic signed [ssi_pkg::COORD_BITS-1:0]  o_base_x,
    output logic signed [ssi_pkg::COORD_BITS-1:0]  o_base_y
);

    localparam int CB  = ssi_pkg::COORD_BITS;
    localparam int DFW = ssi_pkg::DIFF_W;
    localparam int PW  = ssi_pkg::PROD_W;
    localparam int CW  = ssi_pkg::CROSS_W;
    localparam int DW  = ssi_pkg::DIV_W;
    localparam int MW  = ssi_pkg::MAG_W;
    localparam int NW  = ssi_pkg::NUM_W;
    localparam int QW  = CB + FRAC_BITS;
    localparam int PLW = 2 * CB;
    localparam int PHW = 2 * CB + 1;

    // Stage 1: differences.
    logic                  r1_valid;
    logic signed [DFW-1:0] r1_ax, r1_ay, r1_bx, r1_by, r1_dx, r1_dy;
    logic signed [CB-1:0]  r1_a1x, r1_a1y;
    logic signed [DFW-1:0] n1_ax, n1_ay, n1_bx, n1_by, n1_dx, n1_dy;

    assign n1_ax = DFW'(i_item.seg_a_end_x)   - DFW'(i_item.seg_a_start_x);
    assign n1_ay = DFW'(i_item.seg_a_end_y)   - DFW'(i_item.seg_a_start_y);
    assign n1_bx = DFW'(i_item.seg_b_start_x) - DFW'(i_item.seg_b_end_x);
    assign n1_by = DFW'(i_item.seg_b_start_y) - DFW'(i_item.seg_b_end_y);
    assign n1_dx = DFW'(i_item.seg_b_start_x) - DFW'(i_item.seg_a_start_x);
    assign n1_dy = DFW'(i_item.seg_b_start_y) - DFW'(i_item.seg_a_start_y);

    // Stage 2: the six products.
    logic                 r2_valid;
    logic signed [PW-1:0] r2_p_aby, r2_p_ayb, r2_p_dby, r2_p_dyb, r2_p_ady, r2_p_ayd;
    logic signed [DFW-1:0] r2_ax, r2_ay;
    logic signed [CB-1:0] r2_a1x, r2_a1y;
    logic signed [PW-1:0] n2_p_aby, n2_p_ayb, n2_p_dby, n2_p_dyb, n2_p_ady, n2_p_ayd;

    assign n2_p_aby = PW'(r1_ax) * PW'(r1_by);
    assign n2_p_ayb = PW'(r1_ay) * PW'(r1_bx);
    assign n2_p_dby = PW'(r1_dx) * PW'(r1_by);
    assign n2_p_dyb = PW'(r1_dy) * PW'(r1_bx);
    assign n2_p_ady = PW'(r1_ax) * PW'(r1_dy);
    assign n2_p_ayd = PW'(r1_ay) * PW'(r1_dx);

    // Stage 3: determinant and the two numerators.
    logic                  r3_valid;
    logic signed [CW-1:0]  r3_det, r3_rn, r3_sn;
    logic signed [DFW-1:0] r3_ax, r3_ay;
    logic signed [CB-1:0]  r3_a1x, r3_a1y;

    // Stage 4: sign normalization and range test.
    ssi_pkg::t_ctl         r4_ctl;
    ssi_pkg::t_ctl         n4_ctl;
    logic [DW-1:0]         r4_det, r4_rn;
    logic [MW-1:0]         r4_magx, r4_magy;
    logic signed [CB-1:0]  r4_a1x, r4_a1y;
    logic signed [CW-1:0]  det_abs, rn_adj, sn_adj;
    logic signed [DFW-1:0] magx_full, magy_full;
    logic                  det_neg;

    always_comb begin
        det_neg   = r3_det[CW-1];
        det_abs   = det_neg ? -r3_det : r3_det;
        rn_adj    = det_neg ? -r3_rn  : r3_rn;
        sn_adj    = det_neg ? -r3_sn  : r3_sn;
        magx_full = r3_ax[DFW-1] ? -r3_ax : r3_ax;
        magy_full = r3_ay[DFW-1] ? -r3_ay : r3_ay;
        n4_ctl.valid = r3_valid;
        // Both parameters must lie in [0,1], compared on numerators.
        n4_ctl.hit   = (r3_det != '0) && !rn_adj[CW-1] && (rn_adj <= det_abs)
                       && !sn_adj[CW-1] && (sn_adj <= det_abs);
        n4_ctl.neg_x = r3_ax[DFW-1];
        n4_ctl.neg_y = r3_ay[DFW-1];
    end

    // Stage 5: magnitude times numerator, split in two partial products.
    ssi_pkg::t_ctl        r5_ctl;
    logic [2*CB-1:0]      r5_ppx_lo, r5_ppy_lo;
    logic [2*CB:0]        r5_ppx_hi, r5_ppy_hi;
    logic [DW-1:0]        r5_det;
    logic signed [CB-1:0] r5_a1x, r5_a1y;

    // Stage 6: full dividend, loaded into the first cell.
    ssi_pkg::t_ctl        r6_ctl;
    logic [DW-1:0]        r6_rem_x, r6_rem_y, r6_det;
    logic [QW-1:0]        r6_bits_x, r6_bits_y;
    logic signed [CB-1:0] r6_a1x, r6_a1y;
    logic [NW-1:0]        num_x, num_y;

    assign num_x = (NW'(r5_ppx_hi) << CB) + NW'(r5_ppx_lo);
    assign num_y = (NW'(r5_ppy_hi) << CB) + NW'(r5_ppy_lo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_ctl   <= '0;
            r5_ctl   <= '0;
            r6_ctl   <= '0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_ctl   <= n4_ctl;
            r5_ctl   <= r4_ctl;
            r6_ctl   <= r5_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_ax  <= n1_ax;
        r1_ay  <= n1_ay;
        r1_bx  <= n1_bx;
        r1_by  <= n1_by;
        r1_dx  <= n1_dx;
        r1_dy  <= n1_dy;
        r1_a1x <= i_item.seg_a_start_x;
        r1_a1y <= i_item.seg_a_start_y;

        r2_p_aby <= n2_p_aby;
        r2_p_ayb <= n2_p_ayb;
        r2_p_dby <= n2_p_dby;
        r2_p_dyb <= n2_p_dyb;
        r2_p_ady <= n2_p_ady;
        r2_p_ayd <= n2_p_ayd;
        r2_ax    <= r1_ax;
        r2_ay    <= r1_ay;
        r2_a1x   <= r1_a1x;
        r2_a1y   <= r1_a1y;

        r3_det <= CW'(r2_p_aby) - CW'(r2_p_ayb);
        r3_rn  <= CW'(r2_p_dby) - CW'(r2_p_dyb);
        r3_sn  <= CW'(r2_p_ady) - CW'(r2_p_ayd);
        r3_ax  <= r2_ax;
        r3_ay  <= r2_ay;
        r3_a1x <= r2_a1x;
        r3_a1y <= r2_a1y;

        r4_det  <= det_abs[DW-1:0];
        r4_rn   <= rn_adj[DW-1:0];
        r4_magx <= magx_full[MW-1:0];
        r4_magy <= magy_full[MW-1:0];
        r4_a1x  <= r3_a1x;
        r4_a1y  <= r3_a1y;

        r5_ppx_lo <= PLW'(r4_magx) * PLW'(r4_rn[CB-1:0]);
        r5_ppx_hi <= PHW'(r4_magx) * PHW'(r4_rn[DW-1:CB]);
        r5_ppy_lo <= PLW'(r4_magy) * PLW'(r4_rn[CB-1:0]);
        r5_ppy_hi <= PHW'(r4_magy) * PHW'(r4_rn[DW-1:CB]);
        r5_det    <= r4_det;
        r5_a1x    <= r4_a1x;
        r5_a1y    <= r4_a1y;

        // The dividend is num << FRAC_BITS. Its bits above the quotient width
        // form the starting remainder; the rest shift in one per cell.
        r6_rem_x  <= num_x[NW-1:CB];
        r6_rem_y  <= num_y[NW-1:CB];
        r6_bits_x <= QW'(num_x[CB-1:0]) << FRAC_BITS;
        r6_bits_y <= QW'(num_y[CB-1:0]) << FRAC_BITS;
        r6_det    <= r5_det;
        r6_a1x    <= r5_a1x;
        r6_a1y    <= r5_a1y;
    end

    assign o_ctl    = r6_ctl;
    assign o_rem_x  = r6_rem_x;
    assign o_rem_y  = r6_rem_y;
    assign o_bits_x = r6_bits_x;
    assign o_bits_y = r6_bits_y;
    assign o_div    = r6_det;
    assign o_base_x = r6_a1x;
    assign o_base_y = r6_a1y;

endmodule

// File: rtl/ssi_cell.sv
// ============================================================================
// ssi_cell: one restoring division step for both coordinate lanes
// Shifts the next dividend bit into the partial remainder, subtracts the
// divisor when it fits and shifts the quotient bit in at the bottom.
// ============================================================================
module ssi_cell #(
    parameter int QUO_W = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  ssi_pkg::t_ctl                         i_ctl,
    input  logic [ssi_pkg::DIV_W-1:0]             i_rem_x,
    input  logic [ssi_pkg::DIV_W-1:0]             i_rem_y,
    input  logic [QUO_W-1:0]                      i_bits_x,
    input  logic [QUO_W-1:0]                      i_bits_y,
    input  logic [ssi_pkg::DIV_W-1:0]             i_div,
    input  logic signed [ssi_pkg::COORD_BITS-1:0] i_base_x,
    input  logic signed [ssi_pkg::COORD_BITS-1:0] i_base_y,
    output ssi_pkg::t_ctl                         o_ctl,
    output logic [ssi_pkg::DIV_W-1:0]             o_rem_x,
    output logic [ssi_pkg::DIV_W-1:0]             o_rem_y,
    output logic [QUO_W-1:0]                      o_bits_x,
    output logic [QUO_W-1:0]                      o_bits_y,
    output logic [ssi_pkg::DIV_W-1:0]             o_div,
    output logic signed [ssi_pkg::COORD_BITS-1:0] o_base_x,
    output logic signed [ssi_pkg::COORD_BITS-1:0] o_base_y
);

    localparam int DW = ssi_pkg::DIV_W;

    ssi_pkg::t_ctl r_ctl;
    logic [DW-1:0] r_rem_x, r_rem_y, r_div;
    logic [QUO_W-1:0] r_bits_x, r_bits_y;
    logic signed [ssi_pkg::COORD_BITS-1:0] r_base_x, r_base_y;

    logic [DW:0]   trial_x, trial_y, diff_x, diff_y;
    logic          take_x, take_y;
    logic [DW-1:0] n_rem_x, n_rem_y;

    // The bits register carries the unused dividend bits at the top and the
    // quotient bits collected so far at the bottom.
    always_comb begin
        trial_x = {i_rem_x, i_bits_x[QUO_W-1]};
        trial_y = {i_rem_y, i_bits_y[QUO_W-1]};
        diff_x  = trial_x - {1'b0, i_div};
        diff_y  = trial_y - {1'b0, i_div};
        take_x  = (trial_x >= {1'b0, i_div});
        take_y  = (trial_y >= {1'b0, i_div});
        n_rem_x = take_x ? diff_x[DW-1:0] : trial_x[DW-1:0];
        n_rem_y = take_y ? diff_y[DW-1:0] : trial_y[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem_x  <= n_rem_x;
        r_rem_y  <= n_rem_y;
        r_bits_x <= {i_bits_x[QUO_W-2:0], take_x};
        r_bits_y <= {i_bits_y[QUO_W-2:0], take_y};
        r_div    <= i_div;
        r_base_x <= i_base_x;
        r_base_y <= i_base_y;
    end

    assign o_ctl    = r_ctl;
    assign o_rem_x  = r_rem_x;
    assign o_rem_y  = r_rem_y;
    assign o_bits_x = r_bits_x;
    assign o_bits_y = r_bits_y;
    assign o_div    = r_div;
    assign o_base_x = r_base_x;
    assign o_base_y = r_base_y;

endmodule

// File: rtl/segment_segment_intersect_core.sv
// ============================================================================
// segment_segment_intersect_core: 2D segment pair intersection, pipelined
// Tests two segments for a crossing with exact integer cross products and
// returns the crossing point on segment A in signed fixed point.
// ============================================================================
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+----------------------------
//  item    | in  | i_start high, o_busy low | i_item   (t_seg_in)
//  result  | out | o_strobe, one cycle      | o_result (t_seg_out)
//
// One item is taken every cycle while o_busy is low. Each result passes six
// setup stages, one divider cell per quotient bit, and two output stages.
// The depth is set by the chain of restoring division cells.
// Reset is synchronous and clears all valid bits; o_busy is high during
// reset and the cycle after it. The receiver cannot stall the results.
//
module segment_segment_intersect_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  ssi_pkg::t_seg_in  i_item,
    output logic              o_strobe,
    output ssi_pkg::t_seg_out o_result
);

    localparam int CB  = ssi_pkg::COORD_BITS;
    localparam int DW  = ssi_pkg::DIV_W;
    localparam int OW  = ssi_pkg::OUT_W;
    localparam int QW  = CB + FRAC_BITS;
    localparam int VW  = CB + FRAC_BITS + 2;
    localparam int EW  = (VW > OW + 1) ? VW : OW + 1;
    localparam int LAT = QW + 8;

    localparam logic signed [EW-1:0] SAT_HI = EW'(64'sh0000_0000_7FFF_FFFF);
    localparam logic signed [EW-1:0] SAT_LO = EW'(-64'sh0000_0000_8000_0000);

    logic r_run;
    logic accept;

    assign o_busy = !r_run;
    assign accept = i_start && r_run;

    // Chain links: index k feeds cell k, index QW is the last cell's output.
    ssi_pkg::t_ctl        c_ctl    [0:QW];
    logic [DW-1:0]        c_rem_x  [0:QW];
    logic [DW-1:0]        c_rem_y  [0:QW];
    logic [QW-1:0]        c_bits_x [0:QW];
    logic [QW-1:0]        c_bits_y [0:QW];
    logic [DW-1:0]        c_div    [0:QW];
    logic signed [CB-1:0] c_base_x [0:QW];
    logic signed [CB-1:0] c_base_y [0:QW];

    ssi_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (accept),
        .i_item   (i_item),
        .o_ctl    (c_ctl[0]),
        .o_rem_x  (c_rem_x[0]),
        .o_rem_y  (c_rem_y[0]),
        .o_bits_x (c_bits_x[0]),
        .o_bits_y (c_bits_y[0]),
        .o_div    (c_div[0]),
        .o_base_x (c_base_x[0]),
        .o_base_y (c_base_y[0])
    );

    for (genvar k = 0; k < QW; k++) begin : g_cell
        ssi_cell #(
            .QUO_W (QW)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (c_ctl[k]),
            .i_rem_x  (c_rem_x[k]),
            .i_rem_y  (c_rem_y[k]),
            .i_bits_x (c_bits_x[k]),
            .i_bits_y (c_bits_y[k]),
            .i_div    (c_div[k]),
            .i_base_x (c_base_x[k]),
            .i_base_y (c_base_y[k]),
            .o_ctl    (c_ctl[k+1]),
            .o_rem_x  (c_rem_x[k+1]),
            .o_rem_y  (c_rem_y[k+1]),
            .o_bits_x (c_bits_x[k+1]),
            .o_bits_y (c_bits_y[k+1]),
            .o_div    (c_div[k+1]),
            .o_base_x (c_base_x[k+1]),
            .o_base_y (c_base_y[k+1])
        );
    end

    // Output stage A: start point plus or minus the truncated quotient.
    ssi_pkg::t_ctl        r_ctl_a;
    logic signed [VW-1:0] r_va_x, r_va_y;
    logic                 r_fr_x, r_fr_y;
    logic signed [VW-1:0] base_x, base_y, q_x, q_y, n_va_x, n_va_y;

    always_comb begin
        base_x = VW'(c_base_x[QW]) <<< FRAC_BITS;
        base_y = VW'(c_base_y[QW]) <<< FRAC_BITS;
        q_x    = signed'(VW'(c_bits_x[QW]));
        q_y    = signed'(VW'(c_bits_y[QW]));
        n_va_x = c_ctl[QW].neg_x ? base_x - q_x : base_x + q_x;
        n_va_y = c_ctl[QW].neg_y ? base_y - q_y : base_y + q_y;
    end

    // Output stage B: when the division left a remainder, move a value rounded away
    // from zero one step toward zero, then clamp to 32 bits; misses read as zero.
    ssi_pkg::t_seg_out    r_out;
    logic                 r_strobe;
    logic signed [VW-1:0] adj_x, adj_y;
    logic signed [EW-1:0] ext_x, ext_y, sat_x, sat_y;
    ssi_pkg::t_seg_out    n_out;

    always_comb begin
        adj_x = r_va_x;
        if (!r_ctl_a.neg_x && r_fr_x && (r_va_x < 0)) begin
            adj_x = r_va_x + VW'(1);
        end else if (r_ctl_a.neg_x && r_fr_x && (r_va_x > 0)) begin
            adj_x = r_va_x - VW'(1);
        end
        adj_y = r_va_y;
        if (!r_ctl_a.neg_y && r_fr_y && (r_va_y < 0)) begin
            adj_y = r_va_y + VW'(1);
        end else if (r_ctl_a.neg_y && r_fr_y && (r_va_y > 0)) begin
            adj_y = r_va_y - VW'(1);
        end
        ext_x = EW'(adj_x);
        ext_y = EW'(adj_y);
        sat_x = (ext_x > SAT_HI) ? SAT_HI : ((ext_x < SAT_LO) ? SAT_LO : ext_x);
        sat_y = (ext_y > SAT_HI) ? SAT_HI : ((ext_y < SAT_LO) ? SAT_LO : ext_y);
        n_out.hit     = r_ctl_a.hit;
        n_out.cross_x = r_ctl_a.hit ? sat_x[OW-1:0] : '0;
        n_out.cross_y = r_ctl_a.hit ? sat_y[OW-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run    <= 1'b0;
            r_ctl_a  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_run    <= 1'b1;
            r_ctl_a  <= c_ctl[QW];
            r_strobe <= r_ctl_a.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_va_x <= n_va_x;
        r_va_y <= n_va_y;
        r_fr_x <= (c_rem_x[QW] != '0);
        r_fr_y <= (c_rem_y[QW] != '0);
        r_out  <= n_out;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

    // Every accepted item produces its result after the fixed pipeline depth.
    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LAT o_strobe)
        else $error("accepted item produced no result at the pipeline depth");

    // No result appears without an item accepted the pipeline depth before.
    a_latency_bwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(i_start && !o_busy, LAT))
        else $error("result strobe without a matching accepted item");

    // For a hit the divider must end with a remainder below the divisor.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_ctl[QW].valid && c_ctl[QW].hit) |->
        ((c_rem_x[QW] < c_div[QW]) && (c_rem_y[QW] < c_div[QW])))
        else $error("divider remainder not below the determinant");

endmodule

// File: tb/tb_segment_segment_intersect_core.sv
// ============================================================================
// tb_segment_segment_intersect_core: self-checking bench for the segment core
// Sends segment pairs through the start/busy command port with random gaps,
// predicts the hit flag and the Q16.16 crossing point with exact integer math
// and compares every strobed result against the oldest pending prediction.
// ============================================================================
module tb_segment_segment_intersect_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS    = 16;
    localparam int PIPE_LATENCY = ssi_pkg::COORD_BITS + FRAC_BITS + 8;
    localparam int CYCLE_LIMIT  = 200000;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_start;
    logic              o_busy;
    ssi_pkg::t_seg_in  i_item;
    logic              o_strobe;
    ssi_pkg::t_seg_out o_result;

    ssi_pkg::t_seg_out crossing_q[$];
    int                mismatch_count = 0;
    bit                steady_stream  = 1'b0;

    segment_segment_intersect_core #(
        .FRAC_BITS(FRAC_BITS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .i_item  (i_item),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // start + delta * num / den in fixed point, truncated toward zero.
    function automatic logic signed [ssi_pkg::OUT_W-1:0] fixed_point_on(
            longint start, longint delta, longint num, longint den);
        logic [127:0] scaled;
        logic [127:0] quo;
        logic [127:0] den_w;
        longint       mag;
        longint       base;
        longint       v;
        bit           frac;
        mag    = (delta < 0) ? -delta : delta;
        den_w  = 128'(den);
        scaled = (128'(mag) << FRAC_BITS) * 128'(num);
        quo    = scaled / den_w;
        frac   = (scaled % den_w) != 0;
        base   = start * (longint'(1) << FRAC_BITS);
        if (delta >= 0) begin
            v = base + longint'(quo[63:0]);
            if (v < 0 && frac) v = v + 1;
        end else begin
            v = base - longint'(quo[63:0]);
            if (frac && v - 1 >= 0) v = v - 1;
        end
        if (v > longint'(32'sh7fffffff)) v = longint'(32'sh7fffffff);
        if (v < -longint'(32'sh7fffffff) - 1) v = -longint'(32'sh7fffffff) - 1;
        return v[ssi_pkg::OUT_W-1:0];
    endfunction

    function automatic ssi_pkg::t_seg_out predict_crossing(ssi_pkg::t_seg_in it);
        longint            a1x, a1y, a2x, a2y, b1x, b1y, b2x, b2y;
        longint            ax, ay, bx, by, dx, dy;
        longint            det, rn, sn;
        ssi_pkg::t_seg_out res;
        a1x = longint'(it.seg_a_start_x);
        a1y = longint'(it.seg_a_start_y);
        a2x = longint'(it.seg_a_end_x);
        a2y = longint'(it.seg_a_end_y);
        b1x = longint'(it.seg_b_start_x);
        b1y = longint'(it.seg_b_start_y);
        b2x = longint'(it.seg_b_end_x);
        b2y = longint'(it.seg_b_end_y);
        ax  = a2x - a1x;
        ay  = a2y - a1y;
        bx  = b1x - b2x;
        by  = b1y - b2y;
        dx  = b1x - a1x;
        dy  = b1y - a1y;
        det = ax * by - ay * bx;
        rn  = dx * by - dy * bx;
        sn  = ax * dy - ay * dx;
        res = '0;
        if (det == 0) return res;
        if (det < 0) begin
            det = -det;
            rn  = -rn;
            sn  = -sn;
        end
        if (rn < 0 || rn > det || sn < 0 || sn > det) return res;
        res.hit     = 1'b1;
        res.cross_x = fixed_point_on(a1x, ax, rn, det);
        res.cross_y = fixed_point_on(a1y, ay, rn, det);
        return res;
    endfunction

    function automatic ssi_pkg::t_seg_in make_pair(int a1x, int a1y, int a2x, int a2y,
                                                   int b1x, int b1y, int b2x, int b2y);
        ssi_pkg::t_seg_in it;
        it.seg_a_start_x = a1x[ssi_pkg::COORD_BITS-1:0];
        it.seg_a_start_y = a1y[ssi_pkg::COORD_BITS-1:0];
        it.seg_a_end_x   = a2x[ssi_pkg::COORD_BITS-1:0];
        it.seg_a_end_y   = a2y[ssi_pkg::COORD_BITS-1:0];
        it.seg_b_start_x = b1x[ssi_pkg::COORD_BITS-1:0];
        it.seg_b_start_y = b1y[ssi_pkg::COORD_BITS-1:0];
        it.seg_b_end_x   = b2x[ssi_pkg::COORD_BITS-1:0];
        it.seg_b_end_y   = b2y[ssi_pkg::COORD_BITS-1:0];
        return it;
    endfunction

    // Mostly back-to-back items, some short pauses and a few long ones.
    function automatic int pick_gap();
        int roll;
        if (steady_stream) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic int signed_rand(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    task automatic send_segments(ssi_pkg::t_seg_in it);
        int gap;
        i_start <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_busy);
        crossing_q.push_back(predict_crossing(it));
        gap = pick_gap();
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        ssi_pkg::t_seg_out want;
        if (i_rst_n && o_strobe) begin
            if (crossing_q.size() == 0) begin
                $display("%0t: unexpected result hit=%0b x=%0d y=%0d", $time,
                         o_result.hit, o_result.cross_x, o_result.cross_y);
                mismatch_count++;
            end else begin
                want = crossing_q.pop_front();
                if (o_result.hit !== want.hit) begin
                    $display("%0t: hit expected %0b actual %0b", $time, want.hit,
                             o_result.hit);
                    mismatch_count++;
                end
                if (o_result.cross_x !== want.cross_x) begin
                    $display("%0t: cross_x expected %0d actual %0d", $time, want.cross_x,
                             o_result.cross_x);
                    mismatch_count++;
                end
                if (o_result.cross_y !== want.cross_y) begin
                    $display("%0t: cross_y expected %0d actual %0d", $time, want.cross_y,
                             o_result.cross_y);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb_segment_segment_intersect_core: done, errors");
        $finish;
    end

    // Endpoint touches, parallel and collinear pairs, zero-length segments,
    // both orientations of the determinant and the coordinate extremes.
    task automatic test_directed();
        send_segments(make_pair(0, 0, 10, 10, 0, 10, 10, 0));
        send_segments(make_pair(0, 0, 10, 0, 0, -5, 0, 5));
        send_segments(make_pair(0, 0, 10, 0, 10, -5, 10, 5));
        send_segments(make_pair(0, 0, 10, 0, 5, 0, 5, 7));
        send_segments(make_pair(0, 0, 10, 0, 5, -7, 5, 0));
        send_segments(make_pair(0, 0, 10, 0, 11, -5, 11, 5));
        send_segments(make_pair(0, 0, 10, 0, 5, 1, 5, 7));
        send_segments(make_pair(0, 0, 10, 0, 0, 3, 10, 3));
        send_segments(make_pair(0, 0, 10, 0, 5, 0, 15, 0));
        send_segments(make_pair(3, 3, 3, 3, 0, 0, 6, 6));
        send_segments(make_pair(0, 0, 6, 6, 3, 3, 3, 3));
        send_segments(make_pair(0, 0, 10, 10, 10, 0, 0, 10));
        send_segments(make_pair(0, 0, 1, 3, 0, 1, 1, 0));
        send_segments(make_pair(0, 0, -1, -3, 0, -1, -1, 0));
        send_segments(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
        send_segments(make_pair(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767));
        send_segments(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
        send_segments(make_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
                                -32768));
        send_segments(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_segments(make_pair(-32768, 32767, 32767, 32767, -32768, -32768, -32768, 32767));
        send_segments(make_pair(-32768, -32768, 32767, -32767, 0, -32768, 1, 32767));
        send_segments(make_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
    endtask

    // Pairs built around a common point, so most of them hit.
    task automatic test_random_crossings(int count);
        int cx, cy, ux, uy, vx, vy, span;
        int m0, m1, m2, m3;
        for (int i = 0; i < count; i++) begin
            steady_stream = (i >= count / 2) && (i < count / 2 + 40);
            case ($urandom_range(0, 2))
                0: span = 3;
                1: span = 200;
                default: span = 4000;
            endcase
            cx = signed_rand(16000);
            cy = signed_rand(16000);
            ux = signed_rand(span);
            uy = signed_rand(span);
            vx = signed_rand(span);
            vy = signed_rand(span);
            m0 = $urandom_range(0, 3);
            m1 = $urandom_range(0, 3);
            m2 = $urandom_range(0, 3);
            m3 = $urandom_range(0, 3);
            send_segments(make_pair(cx - m0 * ux, cy - m0 * uy, cx + m1 * ux, cy + m1 * uy,
                                    cx - m2 * vx, cy - m2 * vy, cx + m3 * vx, cy + m3 * vy));
        end
        steady_stream = 1'b0;
    endtask

    // Parallel pairs, a quarter of them on the same line.
    task automatic test_random_parallel(int count);
        int sx, sy, dx, dy, ox, oy, k1, k2, t;
        for (int i = 0; i < count; i++) begin
            sx = signed_rand(10000);
            sy = signed_rand(10000);
            dx = signed_rand(1000);
            dy = signed_rand(1000);
            k1 = $urandom_range(1, 3);
            k2 = int'($urandom_range(0, 6)) - 3;
            if ($urandom_range(0, 3) == 0) begin
                t  = int'($urandom_range(0, 4)) - 2;
                ox = t * dx;
                oy = t * dy;
            end else begin
                ox = signed_rand(1000);
                oy = signed_rand(1000);
            end
            send_segments(make_pair(sx, sy, sx + k1 * dx, sy + k1 * dy, sx + ox, sy + oy,
                                    sx + ox + k2 * dx, sy + oy + k2 * dy));
        end
    endtask

    function automatic int noise_coord();
        case ($urandom_range(0, 19))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3: return -1;
            default: return int'($urandom_range(0, 65535));
        endcase
    endfunction

    // Unrelated full-range coordinates: mostly misses, every input bit toggles.
    task automatic test_random_noise(int count);
        for (int i = 0; i < count; i++) begin
            send_segments(make_pair(noise_coord(), noise_coord(), noise_coord(), noise_coord(),
                                    noise_coord(), noise_coord(), noise_coord(),
                                    noise_coord()));
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_start <= 1'b0;
        i_item  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_crossings(250);
        test_random_parallel(40);
        test_random_noise(110);

        i_start <= 1'b0;
        while (crossing_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 10) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("tb_segment_segment_intersect_core: done, clean");
        end else begin
            $display("tb_segment_segment_intersect_core: done, errors");
        end
        $finish;
    end

endmodule
